[sv/lfu_pkg.sv]
// Package for the LFU cache: field widths, payload and entry types, register codes.
// No dependencies; every other file but lfu_ram imports it.
package lfu_pkg;

    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = 32;
    localparam int STAMP_W = 64;
    localparam int CAP_W   = 5;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [CAP_W-1:0] CAP_RESET   = CAP_W'(16);
    localparam logic             CFG_CAP_IDX = 1'b0;

    typedef enum logic
    {
        ACT_GET = 1'b0,
        ACT_SET = 1'b1
    } action_t;

    typedef struct packed
    {
        logic [0:0]       action;
        logic [KEY_W-1:0] lookup_key;
        logic [VAL_W-1:0] write_value;
    } cmd_t;

    typedef struct packed
    {
        logic             hit;
        logic [VAL_W-1:0] read_value;
    } rsp_t;

    typedef struct packed
    {
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   value;
        logic [CNT_W-1:0]   count;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    typedef struct packed
    {
        logic found;
        logic victim_ok;
        logic free_ok;
    } scan_flags_t;

endpackage

[sv/lfu_cache_lookup_insert.sv]
// Top level of the LFU cache with LRU tie break: sequencer, valid bits, APB register.
// Depends on lfu_pkg, lfu_ram, lfu_scan.
//
//   channel   signals                                  handshake
//   command   start, busy, cmd (action/key/value)      start & !busy
//   result    done, rsp (hit/read_value)               done, one cycle
//   config    psel, penable, pwrite, paddr, pwdata     psel & penable & pwrite
//
// An item runs from accept to result through these steps in order:
// one RAM read per entry through the shared compare unit, a drain state, one write-back.
// busy falls at the edge that raises done, so a new command may be accepted in the cycle
// done is shown; no new command is accepted while one is in flight.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset clears valid bits, occupancy and stamp clock and sets capacity to 16; no clearing pass.
module lfu_cache_lookup_insert #(
    parameter int ENTRIES = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  lfu_pkg::cmd_t               cmd,
    output logic                        done,
    output lfu_pkg::rsp_t               rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lfu_pkg::PADDR_W-1:0] paddr,
    input  logic [lfu_pkg::PDATA_W-1:0] pwdata,
    output logic [lfu_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import lfu_pkg::*;

    localparam int IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    typedef enum logic [3:0]
    {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_LAST   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [IW-1:0]      scan_idx_reg;
    logic               eval_reg;
    logic [IW-1:0]      eval_idx_reg;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [OCC_W-1:0]   occ_reg, occ_next;
    logic [STAMP_W-1:0] clock_reg, clock_next;
    logic [CAP_W-1:0]   cap_reg;
    cmd_t               cmd_reg;
    rsp_t               rsp_reg, rsp_next;
    logic               done_reg;

    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    entry_t             ram_wdata;
    logic [$bits(entry_t)-1:0] ram_rdata;

    scan_flags_t        flags;
    logic [IW-1:0]      found_idx, victim_idx, free_idx, slot_idx;
    entry_t             found_entry;
    logic [CNT_W-1:0]   count_inc;
    logic [CMP_W-1:0]   cap_eff;
    logic               evict, cfg_wr;

    lfu_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_idx_reg),
        .rdata (ram_rdata)
    );

    lfu_scan #(
        .ENTRIES (ENTRIES)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear       (state_reg == ST_IDLE),
        .eval        (eval_reg),
        .eval_idx    (eval_idx_reg),
        .eval_valid  (valid_reg[eval_idx_reg]),
        .eval_entry  (entry_t'(ram_rdata)),
        .key         (cmd_reg.lookup_key),
        .flags       (flags),
        .found_idx   (found_idx),
        .found_entry (found_entry),
        .victim_idx  (victim_idx),
        .free_idx    (free_idx)
    );

    always_comb
    begin
        cap_eff   = (CMP_W'(cap_reg) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : CMP_W'(cap_reg);
        evict     = (CMP_W'(occ_reg) >= cap_eff) && flags.victim_ok;
        slot_idx  = (!evict) ? free_idx :
                    ((flags.free_ok && (free_idx < victim_idx)) ? free_idx : victim_idx);
        count_inc = (found_entry.count == '1) ? found_entry.count : found_entry.count + 1'b1;

        state_next = state_reg;
        valid_next = valid_reg;
        occ_next   = occ_reg;
        clock_next = clock_reg;
        rsp_next   = rsp_reg;
        ram_we     = 1'b0;
        ram_waddr  = found_idx;
        ram_wdata  = found_entry;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                state_next          = ST_IDLE;
                rsp_next.hit        = flags.found;
                rsp_next.read_value = '0;
                if (cmd_reg.action == ACT_GET)
                begin
                    if (flags.found)
                    begin
                        rsp_next.read_value = found_entry.value;
                        ram_we              = 1'b1;
                        ram_wdata.count     = count_inc;
                        ram_wdata.stamp     = clock_reg;
                        clock_next          = clock_reg + 1'b1;
                    end
                end
                else if (cap_eff != '0)
                begin
                    if (flags.found)
                    begin
                        ram_we          = 1'b1;
                        ram_wdata.value = cmd_reg.write_value;
                        ram_wdata.count = count_inc;
                        ram_wdata.stamp = clock_reg;
                        clock_next      = clock_reg + 1'b1;
                    end
                    else if (evict || flags.free_ok)
                    begin
                        ram_we          = 1'b1;
                        ram_waddr       = slot_idx;
                        ram_wdata.key   = cmd_reg.lookup_key;
                        ram_wdata.value = cmd_reg.write_value;
                        ram_wdata.count = CNT_W'(1);
                        ram_wdata.stamp = clock_reg;
                        clock_next      = clock_reg + 1'b1;
                        if (evict)
                        begin
                            valid_next[victim_idx] = 1'b0;
                        end
                        else
                        begin
                            occ_next = occ_reg + 1'b1;
                        end
                        valid_next[slot_idx] = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == CFG_CAP_IDX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            scan_idx_reg <= '0;
            eval_reg     <= 1'b0;
            valid_reg    <= '0;
            occ_reg      <= '0;
            clock_reg    <= '0;
            cap_reg      <= CAP_RESET;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            eval_reg  <= (state_reg == ST_SCAN);
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
            clock_reg <= clock_next;
            done_reg  <= (state_reg == ST_FINISH);
            if (state_reg == ST_SCAN)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
            else
            begin
                scan_idx_reg <= '0;
            end
            if (cfg_wr)
            begin
                cap_reg <= pwdata[CAP_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        eval_idx_reg <= scan_idx_reg;
        rsp_reg      <= rsp_next;
        if ((state_reg == ST_IDLE) && start)
        begin
            cmd_reg <= cmd;
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign rsp    = rsp_reg;
    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1] == CFG_CAP_IDX) ? PDATA_W'(cap_reg) : '0;

endmodule

[sv/lfu_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/lfu_scan.sv]
// Shared compare unit for the entry scan: key match, LFU/LRU victim, first free slot.
// Depends on lfu_pkg.
module lfu_scan #(
    parameter int ENTRIES = 16,
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      clear,
    input  logic                      eval,
    input  logic [IW-1:0]             eval_idx,
    input  logic                      eval_valid,
    input  lfu_pkg::entry_t           eval_entry,
    input  logic [lfu_pkg::KEY_W-1:0] key,
    output lfu_pkg::scan_flags_t      flags,
    output logic [IW-1:0]             found_idx,
    output lfu_pkg::entry_t           found_entry,
    output logic [IW-1:0]             victim_idx,
    output logic [IW-1:0]             free_idx
);
    import lfu_pkg::*;

    scan_flags_t        flags_reg, flags_next;
    logic [IW-1:0]      found_idx_reg;
    entry_t             found_entry_reg;
    logic [IW-1:0]      victim_idx_reg;
    logic [CNT_W-1:0]   best_cnt_reg;
    logic [STAMP_W-1:0] best_stamp_reg;
    logic [IW-1:0]      free_idx_reg;
    logic               take_found, take_victim, take_free;

    always_comb
    begin
        take_found  = eval && eval_valid && !flags_reg.found && (eval_entry.key == key);
        take_victim = eval && eval_valid &&
                      (!flags_reg.victim_ok || (eval_entry.count < best_cnt_reg) ||
                       ((eval_entry.count == best_cnt_reg) &&
                        (eval_entry.stamp < best_stamp_reg)));
        take_free   = eval && !eval_valid && !flags_reg.free_ok;
        flags_next  = flags_reg;
        if (clear)
        begin
            flags_next = '0;
        end
        else
        begin
            if (take_found)
            begin
                flags_next.found = 1'b1;
            end
            if (take_victim)
            begin
                flags_next.victim_ok = 1'b1;
            end
            if (take_free)
            begin
                flags_next.free_ok = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!clear)
        begin
            if (take_found)
            begin
                found_idx_reg   <= eval_idx;
                found_entry_reg <= eval_entry;
            end
            if (take_victim)
            begin
                victim_idx_reg <= eval_idx;
                best_cnt_reg   <= eval_entry.count;
                best_stamp_reg <= eval_entry.stamp;
            end
            if (take_free)
            begin
                free_idx_reg <= eval_idx;
            end
        end
    end

    assign flags       = flags_reg;
    assign found_idx   = found_idx_reg;
    assign found_entry = found_entry_reg;
    assign victim_idx  = victim_idx_reg;
    assign free_idx    = free_idx_reg;

endmodule

[sv/lfu_checker.sv]
// Port-level checks for the LFU cache top level, attached by bind.
// Depends on lfu_pkg and lfu_cache_lookup_insert.
module lfu_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input lfu_pkg::rsp_t rsp
);
    import lfu_pkg::*;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after command transfer");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_done_prev_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a command in flight");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !rsp.hit) |-> (rsp.read_value == '0))
        else $error("miss returned nonzero data");

endmodule

bind lfu_cache_lookup_insert lfu_checker u_lfu_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

[bench/testbench.sv]
// Testbench for lfu_cache_lookup_insert: directed table, then random get/set traffic per capacity.
// Checks results against table values or an in-bench LFU/LRU model; capacity is written over APB.
// Depends on lfu_pkg and the lfu_cache_lookup_insert RTL.
module testbench;

    import lfu_pkg::*;

    localparam int SLOTS        = 16;
    localparam int RANDOM_ITEMS = 1650;
    localparam int PHASES       = 11;
    localparam int DRAIN_CYCLES = 2 * (SLOTS + 3);
    localparam int POOL_MAX     = 32;

    localparam logic [PADDR_W-1:0] CAP_ADDR   = {CFG_CAP_IDX, 2'b00};
    localparam logic [PADDR_W-1:0] SPARE_ADDR = {~CFG_CAP_IDX, 2'b00};

    typedef enum logic [1:0]
    {
        ROW_ITEM,
        ROW_CAP,
        ROW_SPARE
    } row_kind_t;

    typedef struct
    {
        row_kind_t kind;
        cmd_t      c;
        logic      typed;
        rsp_t      want;
    } stim_row_t;

    logic                clk;
    logic                rst_n   = 1'b0;
    logic                start   = 1'b0;
    cmd_t                cmd     = '0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [PDATA_W-1:0]  pwdata  = '0;
    logic                busy;
    logic                done;
    rsp_t                rsp;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    logic                slot_valid [SLOTS];
    logic [KEY_W-1:0]    slot_key   [SLOTS];
    logic [VAL_W-1:0]    slot_value [SLOTS];
    logic [CNT_W-1:0]    slot_count [SLOTS];
    logic [STAMP_W-1:0]  slot_stamp [SLOTS];
    logic [STAMP_W-1:0]  stamp_now;
    int                  occupancy;
    logic [CAP_W-1:0]    capacity;

    rsp_t                results_due [$];
    stim_row_t           script [$];
    logic [KEY_W-1:0]    key_pool [POOL_MAX];
    int                  cap_plan [PHASES] = '{16, 1, 0, 3, 31, 8, 17, 2, 16, 5, 12};
    int                  errors = 0;

    lfu_cache_lookup_insert #(
        .ENTRIES (SLOTS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .done    (done),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("lfu_cache_lookup_insert test failed");
        $finish;
    end

    function automatic void renew_slot(int s);
        if (slot_count[s] != '1)
            slot_count[s] = slot_count[s] + 1'b1;
        slot_stamp[s] = stamp_now;
        stamp_now     = stamp_now + 1'b1;
    endfunction

    function automatic rsp_t lfu_access(cmd_t c);
        rsp_t r;
        int   hit_slot;
        int   victim;
        int   limit;
        logic placed;
        hit_slot = -1;
        victim   = -1;
        placed   = 1'b0;
        limit    = (int'(capacity) > SLOTS) ? SLOTS : int'(capacity);
        for (int i = 0; i < SLOTS; i++)
            if (hit_slot < 0 && slot_valid[i] && slot_key[i] == c.lookup_key)
                hit_slot = i;
        r.hit        = (hit_slot >= 0);
        r.read_value = '0;
        if (c.action == ACT_GET)
        begin
            if (hit_slot >= 0)
            begin
                r.read_value = slot_value[hit_slot];
                renew_slot(hit_slot);
            end
        end
        else if (limit != 0)
        begin
            if (hit_slot >= 0)
            begin
                slot_value[hit_slot] = c.write_value;
                renew_slot(hit_slot);
            end
            else
            begin
                if (occupancy >= limit)
                begin
                    for (int i = 0; i < SLOTS; i++)
                        if (slot_valid[i] && (victim < 0 || slot_count[i] < slot_count[victim] ||
                            (slot_count[i] == slot_count[victim] &&
                             slot_stamp[i] < slot_stamp[victim])))
                            victim = i;
                    if (victim >= 0)
                    begin
                        slot_valid[victim] = 1'b0;
                        occupancy--;
                    end
                end
                for (int i = 0; i < SLOTS; i++)
                    if (!placed && !slot_valid[i])
                    begin
                        slot_valid[i] = 1'b1;
                        slot_key[i]   = c.lookup_key;
                        slot_value[i] = c.write_value;
                        slot_count[i] = CNT_W'(1);
                        slot_stamp[i] = stamp_now;
                        stamp_now     = stamp_now + 1'b1;
                        occupancy++;
                        placed        = 1'b1;
                    end
            end
        end
        return r;
    endfunction

    function automatic void add_row(row_kind_t k, action_t act, logic [KEY_W-1:0] key,
                                    logic [VAL_W-1:0] val, logic typed, logic h,
                                    logic [VAL_W-1:0] rv);
        stim_row_t row;
        row.kind               = k;
        row.c.action           = act;
        row.c.lookup_key       = key;
        row.c.write_value      = val;
        row.typed              = typed;
        row.want.hit           = h;
        row.want.read_value    = rv;
        script.insert(script.size(), row);
    endfunction

    function automatic cmd_t random_cmd(int pool_n);
        cmd_t c;
        c.action      = $urandom_range(0, 1) ? ACT_SET : ACT_GET;
        c.lookup_key  = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom)
                                                    : key_pool[$urandom_range(0, pool_n - 1)];
        c.write_value = VAL_W'($urandom);
        return c;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        if (r < 85)
            return $urandom_range(1, 4);
        if (r < 97)
            return $urandom_range(5, 25);
        return $urandom_range(26, 80);
    endfunction

    task automatic issue_cmd(cmd_t c, logic typed, rsp_t want);
        rsp_t r;
        start <= 1'b1;
        cmd   <= c;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        r = lfu_access(c);
        results_due.insert(results_due.size(), typed ? want : r);
    endtask

    task automatic hold_off(logic steady);
        int g;
        g = steady ? 0 : pick_gap();
        if (g > 0)
        begin
            start <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(logic [PADDR_W-1:0] a, logic [PDATA_W-1:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready)
            @(negedge clk);
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read_check(logic [PADDR_W-1:0] a, logic [PDATA_W-1:0] want);
        logic [PDATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= a;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready)
            @(negedge clk);
        got = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want)
        begin
            $display("%0t: capacity readback mismatch: expected %0d, got %0d", $time, want, got);
            errors++;
        end
    endtask

    task automatic program_reg(logic [PADDR_W-1:0] a, logic [PDATA_W-1:0] d);
        wait_idle();
        apb_write(a, d);
        if (a == CAP_ADDR)
            capacity = d[CAP_W-1:0];
        @(posedge clk);
        apb_read_check(CAP_ADDR, PDATA_W'(capacity));
    endtask

    always @(negedge clk)
    begin
        rsp_t want;
        if (rst_n && done)
        begin
            if (results_due.size() == 0)
            begin
                $display("%0t: unexpected result: hit %0b, read_value %h",
                         $time, rsp.hit, rsp.read_value);
                errors++;
            end
            else
            begin
                want = results_due[0];
                results_due.delete(0);
                if (rsp.hit !== want.hit)
                begin
                    $display("%0t: hit mismatch: expected %0b, got %0b",
                             $time, want.hit, rsp.hit);
                    errors++;
                end
                if (rsp.read_value !== want.read_value)
                begin
                    $display("%0t: read_value mismatch: expected %h, got %h",
                             $time, want.read_value, rsp.read_value);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int   pool_n;
        int   per_phase;
        logic steady;
        logic [PDATA_W-1:0] wdata;
        for (int i = 0; i < SLOTS; i++)
            slot_valid[i] = 1'b0;
        stamp_now = '0;
        occupancy = 0;
        capacity  = CAP_RESET;

        add_row(ROW_ITEM, ACT_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0);
        add_row(ROW_ITEM, ACT_SET, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0);
        add_row(ROW_ITEM, ACT_GET, 32'h0000_0000, 32'h1357_9BDF, 1'b1, 1'b1, 32'hFFFF_FFFF);
        add_row(ROW_ITEM, ACT_SET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0);
        add_row(ROW_ITEM, ACT_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0);
        add_row(ROW_ITEM, ACT_SET, 32'h0000_0000, 32'h1234_5678, 1'b1, 1'b1, 32'h0);
        add_row(ROW_ITEM, ACT_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h1234_5678);
        add_row(ROW_ITEM, ACT_GET, 32'hA5A5_A5A5, 32'h0000_0000, 1'b1, 1'b0, 32'h0);
        add_row(ROW_ITEM, ACT_SET, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 1'b1, 1'b0, 32'h0);
        add_row(ROW_ITEM, ACT_GET, 32'h5A5A_5A5A, 32'h0000_0000, 1'b1, 1'b1, 32'hA5A5_A5A5);
        // shrink below occupancy: the insert evicts the least used, oldest entry
        add_row(ROW_CAP,  ACT_GET, 32'h0,         32'd2,         1'b0, 1'b0, 32'h0);
        add_row(ROW_ITEM, ACT_SET, 32'h0000_0100, 32'h0000_0001, 1'b1, 1'b0, 32'h0);
        add_row(ROW_ITEM, ACT_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0);
        add_row(ROW_ITEM, ACT_GET, 32'h0000_0100, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0001);
        // capacity zero: sets report presence but change nothing
        add_row(ROW_CAP,  ACT_GET, 32'h0,         32'hFFFF_FFE0, 1'b0, 1'b0, 32'h0);
        add_row(ROW_ITEM, ACT_SET, 32'h0000_0100, 32'h0000_0002, 1'b1, 1'b1, 32'h0);
        add_row(ROW_ITEM, ACT_GET, 32'h0000_0100, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0001);
        add_row(ROW_ITEM, ACT_SET, 32'h0000_0200, 32'h0000_0003, 1'b1, 1'b0, 32'h0);
        add_row(ROW_ITEM, ACT_GET, 32'h0000_0200, 32'h0000_0000, 1'b1, 1'b0, 32'h0);
        // write to an unmapped register: capacity stays zero
        add_row(ROW_SPARE, ACT_GET, 32'h0,        32'h0000_0010, 1'b0, 1'b0, 32'h0);
        add_row(ROW_ITEM, ACT_SET, 32'h0000_0300, 32'h0000_0004, 1'b1, 1'b0, 32'h0);
        add_row(ROW_ITEM, ACT_GET, 32'h0000_0300, 32'h0000_0000, 1'b1, 1'b0, 32'h0);
        // capacity above the entry count acts as full size
        add_row(ROW_CAP,  ACT_GET, 32'h0,         32'd31,        1'b0, 1'b0, 32'h0);
        add_row(ROW_ITEM, ACT_SET, 32'h0000_0300, 32'h0000_0004, 1'b1, 1'b0, 32'h0);
        add_row(ROW_ITEM, ACT_GET, 32'h0000_0300, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0004);
        add_row(ROW_CAP,  ACT_GET, 32'h0,         32'd1,         1'b0, 1'b0, 32'h0);
        add_row(ROW_ITEM, ACT_SET, 32'h0000_0400, 32'h0000_0005, 1'b1, 1'b0, 32'h0);
        add_row(ROW_ITEM, ACT_GET, 32'h0000_0400, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0005);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        apb_read_check(CAP_ADDR, PDATA_W'(CAP_RESET));
        @(posedge clk);

        foreach (script[i])
        begin
            case (script[i].kind)
                ROW_CAP:   program_reg(CAP_ADDR, script[i].c.write_value);
                ROW_SPARE: program_reg(SPARE_ADDR, script[i].c.write_value);
                default:
                begin
                    issue_cmd(script[i].c, script[i].typed, script[i].want);
                    hold_off(i % 3 == 0);
                end
            endcase
        end

        per_phase = RANDOM_ITEMS / PHASES;
        for (int p = 0; p < PHASES; p++)
        begin
            wdata = $urandom_range(0, 1) ? (PDATA_W'($urandom) & ~PDATA_W'(32'h1F)) : '0;
            program_reg(CAP_ADDR, wdata | PDATA_W'(cap_plan[p]));
            if ($urandom_range(0, 3) == 0)
            begin
                @(posedge clk);
                program_reg(SPARE_ADDR, PDATA_W'($urandom));
            end
            pool_n = $urandom_range(2, 24);
            for (int k = 0; k < POOL_MAX; k++)
                key_pool[k] = KEY_W'($urandom);
            if ($urandom_range(0, 1))
            begin
                key_pool[0] = '0;
                key_pool[1] = '1;
            end
            steady = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < per_phase; n++)
            begin
                issue_cmd(random_cmd(pool_n), 1'b0, '0);
                hold_off(steady);
            end
        end

        wait_idle();
        if (errors == 0)
            $display("lfu_cache_lookup_insert test passed");
        else
            $display("lfu_cache_lookup_insert test failed");
        $finish;
    end

endmodule

[filelist.f]
sv/lfu_pkg.sv
sv/lfu_ram.sv
sv/lfu_scan.sv
sv/lfu_cache_lookup_insert.sv
sv/lfu_checker.sv
bench/testbench.sv
